FILE: design/dtok_pkg.sv
// ----------------------------------------------------------------------------
// dtok_pkg - shared types, constants and token ROM for the detokenizer
// Command format between front and back, status codes, token text tables.
// ----------------------------------------------------------------------------
package dtok_pkg;

    localparam int MAX_TOKEN_BYTES_DEF = 16;
    localparam int FIFO_DEPTH_DEF      = 4;

    // longest table entry in bytes; text is stored left-justified
    localparam int TXT_BYTES = 13;
    localparam int TXT_W     = 8 * TXT_BYTES;
    localparam int LEN_W     = 4;

    localparam logic [16:0] POS_MAX      = 17'h1FFFF;
    localparam logic [16:0] DATA_LEN_POS = 17'h00035;
    localparam logic [16:0] DATA_POS     = 17'h00037;
    localparam logic [16:0] MIN_FILE     = 17'h00039;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SMALL     = 4'd1;
    localparam logic [3:0] ST_SIG       = 4'd2;
    localparam logic [3:0] ST_DLEN      = 4'd3;
    localparam logic [3:0] ST_HDR_TRUNC = 4'd4;
    localparam logic [3:0] ST_HDR_SIZE  = 4'd5;
    localparam logic [3:0] ST_NOT_PRGM  = 4'd6;
    localparam logic [3:0] ST_NO_BLEN   = 4'd7;
    localparam logic [3:0] ST_BODY_PAST = 4'd8;

    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_NAME,
        OP_THETA,
        OP_TOKEN
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [8:0]  pfx;       // bit 8: two-byte token
        logic [7:0]  data;
        logic [15:0] tally;     // count carried by text results
        logic        has_status;
        logic [3:0]  code;
        logic [15:0] scount;
    } cmd_t;

    typedef struct packed {
        logic [TXT_W-1:0] txt;
        logic [LEN_W-1:0] len;
        logic             known;
    } tok_rom_t;

    function automatic logic is_prefix(input logic [7:0] b);
        return b == 8'h5C || b == 8'h5D || b == 8'h5E || b == 8'h60 || b == 8'h62 ||
               b == 8'h63 || b == 8'h7E || b == 8'hAA || b == 8'hBB || b == 8'hEF;
    endfunction

    function automatic logic [7:0] sig_byte(input logic [2:0] k);
        logic [7:0] r;
        unique case (k)
            3'd0:    r = 8'h2A;
            3'd1:    r = 8'h2A;
            3'd2:    r = 8'h54;
            3'd3:    r = 8'h49;
            3'd4:    r = 8'h38;
            3'd5:    r = 8'h33;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // right-justified literal -> left-justified text with length
    function automatic tok_rom_t lj(input logic [TXT_W-1:0] s);
        tok_rom_t r;
        int n;
        n = 0;
        for (int i = 0; i < TXT_BYTES; i++) begin
            if (s[8*i +: 8] != 8'h00) n++;
        end
        r.len   = LEN_W'(n);
        r.txt   = s << (8 * (TXT_BYTES - n));
        r.known = (n != 0);
        return r;
    endfunction

    function automatic tok_rom_t tok_lookup(input logic [8:0] pfx, input logic [7:0] b);
        logic [TXT_W-1:0] s;
        logic [7:0] dg;
        tok_rom_t r;
        s  = '0;
        dg = (b == 8'h09) ? 8'h30 : 8'h31 + b;
        if (!pfx[8]) begin
            unique case (b)
                8'h01: s = "\xE2\x96\xB6DMS";
                8'h02: s = "\xE2\x96\xB6Dec";
                8'h03: s = "\xE2\x96\xB6Frac";
                8'h04: s = "\xE2\x86\x92";
                8'h05: s = "Boxplot";
                8'h06: s = "[";
                8'h07: s = "]";
                8'h08: s = "{";
                8'h09: s = "}";
                8'h0A: s = "\xCA\xB3";
                8'h0B: s = "\xC2\xB0";
                8'h0C: s = "^-1";
                8'h0D: s = "^2";
                8'h0E: s = "^T";
                8'h0F: s = "^3";
                8'h10: s = "(";
                8'h11: s = ")";
                8'h12: s = "round(";
                8'h13: s = "pxl-Test(";
                8'h14: s = "augment(";
                8'h15: s = "rowSwap(";
                8'h16: s = "row+(";
                8'h17: s = "*row(";
                8'h18: s = "*row+(";
                8'h19: s = "max(";
                8'h1A: s = "min(";
                8'h1B: s = "R\xE2\x96\xB6Pr(";
                8'h1C: s = "R\xE2\x96\xB6P\xCE\xB8(";
                8'h1D: s = "P\xE2\x96\xB6Rx(";
                8'h1E: s = "P\xE2\x96\xB6Ry(";
                8'h1F: s = "median(";
                8'h20: s = "randM(";
                8'h21: s = "mean(";
                8'h22: s = "solve(";
                8'h23: s = "seq(";
                8'h24: s = "fnInt(";
                8'h25: s = "nDeriv(";
                8'h27: s = "fMin(";
                8'h28: s = "fMax(";
                8'h29: s = " ";
                8'h2A: s = "\"";
                8'h2B: s = ",";
                8'h2C: s = "i";
                8'h2D: s = "!";
                8'h2E: s = "CubicReg ";
                8'h2F: s = "QuartReg ";
                8'h30: s = "0";
                8'h31: s = "1";
                8'h32: s = "2";
                8'h33: s = "3";
                8'h34: s = "4";
                8'h35: s = "5";
                8'h36: s = "6";
                8'h37: s = "7";
                8'h38: s = "8";
                8'h39: s = "9";
                8'h3A: s = ".";
                8'h3B: s = "E";
                8'h3C: s = " xor ";
                8'h3E: s = ":";
                8'h3F: s = "\n";
                8'h40: s = " and ";
                8'h41: s = "A";
                8'h42: s = "B";
                8'h43: s = "C";
                8'h44: s = "D";
                8'h45: s = "E";
                8'h46: s = "F";
                8'h47: s = "G";
                8'h48: s = "H";
                8'h49: s = "I";
                8'h4A: s = "J";
                8'h4B: s = "K";
                8'h4C: s = "L";
                8'h4D: s = "M";
                8'h4E: s = "N";
                8'h4F: s = "O";
                8'h50: s = "P";
                8'h51: s = "Q";
                8'h52: s = "R";
                8'h53: s = "S";
                8'h54: s = "T";
                8'h55: s = "U";
                8'h56: s = "V";
                8'h57: s = "W";
                8'h58: s = "X";
                8'h59: s = "Y";
                8'h5A: s = "Z";
                8'h5B: s = "\xCE\xB8";
                8'h5F: s = "prgm";
                8'h64: s = "Radian";
                8'h65: s = "Degree";
                8'h66: s = "Normal";
                8'h67: s = "Sci";
                8'h68: s = "Eng";
                8'h69: s = "Float";
                8'h6A: s = "=";
                8'h6B: s = "<";
                8'h6C: s = ">";
                8'h6D: s = "\xE2\x89\xA4";
                8'h6E: s = "\xE2\x89\xA5";
                8'h6F: s = "\xE2\x89\xA0";
                8'h70: s = "+";
                8'h71: s = "-";
                8'h72: s = "Ans";
                8'h73: s = "Fix ";
                8'h74: s = "Horiz";
                8'h75: s = "Full";
                8'h76: s = "Func";
                8'h77: s = "Param";
                8'h78: s = "Polar";
                8'h79: s = "Seq";
                8'h82: s = "*";
                8'h83: s = "/";
                8'h84: s = "Trace";
                8'h85: s = "ClrDraw";
                8'h86: s = "ZStandard";
                8'h87: s = "ZTrig";
                8'h88: s = "ZBox";
                8'h89: s = "Zoom In";
                8'h8A: s = "Zoom Out";
                8'h8B: s = "ZSquare";
                8'h8C: s = "ZInteger";
                8'h8D: s = "ZPrevious";
                8'h8E: s = "ZDecimal";
                8'h8F: s = "ZoomStat";
                8'h90: s = "ZoomRcl";
                8'h91: s = "PrintScreen";
                8'h92: s = "ZoomSto";
                8'h93: s = "Text(";
                8'h94: s = " nPr ";
                8'h95: s = " nCr ";
                8'h96: s = "FnOn ";
                8'h97: s = "FnOff ";
                8'h98: s = "StorePic ";
                8'h99: s = "RecallPic ";
                8'h9A: s = "StoreGDB ";
                8'h9B: s = "RecallGDB ";
                8'h9C: s = "Line(";
                8'h9D: s = "Vertical ";
                8'h9E: s = "Pt-On(";
                8'h9F: s = "Pt-Off(";
                8'hA0: s = "Pt-Change(";
                8'hA1: s = "Pxl-On(";
                8'hA2: s = "Pxl-Off(";
                8'hA3: s = "Pxl-Change(";
                8'hA4: s = "Shade(";
                8'hA5: s = "Circle(";
                8'hA6: s = "Horizontal ";
                8'hA7: s = "Tangent(";
                8'hA8: s = "DrawInv ";
                8'hA9: s = "DrawF ";
                8'hAB: s = "rand";
                8'hAC: s = "\xCF\x80";
                8'hAD: s = "getKey";
                8'hAE: s = "'";
                8'hAF: s = "?";
                8'hB0: s = "-";
                8'hB1: s = "int(";
                8'hB2: s = "abs(";
                8'hB3: s = "det(";
                8'hB4: s = "identity(";
                8'hB5: s = "dim(";
                8'hB6: s = "sum(";
                8'hB7: s = "prod(";
                8'hB8: s = "not(";
                8'hB9: s = "iPart(";
                8'hBA: s = "fPart(";
                8'hBC: s = "\xE2\x88\x9A(";
                8'hBD: s = "\xC2\xB3\xE2\x88\x9A(";
                8'hBE: s = "ln(";
                8'hBF: s = "e^(";
                8'hC0: s = "log(";
                8'hC1: s = "10^(";
                8'hC2: s = "sin(";
                8'hC3: s = "sin^-1(";
                8'hC4: s = "cos(";
                8'hC5: s = "cos^-1(";
                8'hC6: s = "tan(";
                8'hC7: s = "tan^-1(";
                8'hC8: s = "sinh(";
                8'hC9: s = "sinh^-1(";
                8'hCA: s = "cosh(";
                8'hCB: s = "cosh^-1(";
                8'hCC: s = "tanh(";
                8'hCD: s = "tanh^-1(";
                8'hCE: s = "If ";
                8'hCF: s = "Then";
                8'hD0: s = "Else";
                8'hD1: s = "While ";
                8'hD2: s = "Repeat ";
                8'hD3: s = "For(";
                8'hD4: s = "End";
                8'hD5: s = "Return";
                8'hD6: s = "Lbl ";
                8'hD7: s = "Goto ";
                8'hD8: s = "Pause ";
                8'hD9: s = "Stop";
                8'hDA: s = "IS>(";
                8'hDB: s = "DS<(";
                8'hDC: s = "Input ";
                8'hDD: s = "Prompt ";
                8'hDE: s = "Disp ";
                8'hDF: s = "DispGraph";
                8'hE0: s = "Output(";
                8'hE1: s = "ClrHome";
                8'hE2: s = "Fill(";
                8'hE3: s = "SortA(";
                8'hE4: s = "SortD(";
                8'hE5: s = "DispTable";
                8'hE6: s = "Menu(";
                8'hE7: s = "Send(";
                8'hE8: s = "Get(";
                8'hE9: s = "PlotsOn ";
                8'hEA: s = "PlotsOff ";
                8'hEB: s = "L";
                8'hEC: s = "Plot1(";
                8'hED: s = "Plot2(";
                8'hEE: s = "Plot3(";
                8'hF0: s = "^";
                8'hF1: s = "\xCB\xA3\xE2\x88\x9A";
                8'hF2: s = "1-Var Stats ";
                8'hF3: s = "2-Var Stats ";
                8'hF4: s = "LinReg(a+bx) ";
                8'hF5: s = "ExpReg ";
                8'hF6: s = "LnReg ";
                8'hF7: s = "PwrReg ";
                8'hF8: s = "Med-Med ";
                8'hF9: s = "QuadReg ";
                8'hFA: s = "ClrList ";
                8'hFB: s = "ClrTable";
                8'hFC: s = "Histogram";
                8'hFD: s = "xyLine";
                8'hFE: s = "Scatter";
                8'hFF: s = "LinReg(ax+b) ";
                default: s = '0;
            endcase
        end else begin
            // generated families first, then the explicit pair table
            if (pfx[7:0] == 8'h5C && b < 8'h0A) begin
                s = TXT_W'({8'h5B, 8'h41 + b, 8'h5D});
            end else if (pfx[7:0] == 8'h60 && b < 8'h0A) begin
                s = TXT_W'({8'h50, 8'h69, 8'h63, dg});
            end else if (pfx[7:0] == 8'hAA && b < 8'h0A) begin
                s = TXT_W'({8'h53, 8'h74, 8'h72, dg});
            end else if (pfx[7:0] == 8'h5D && b < 8'h06) begin
                s = TXT_W'({8'h4C, 8'h31 + b});
            end else if (pfx[7:0] == 8'h5E && b >= 8'h10 && b <= 8'h19) begin
                s = TXT_W'({8'h59, (b == 8'h19) ? 8'h30 : 8'h30 + (b - 8'h0F)});
            end else if (pfx[7:0] == 8'h5E && b >= 8'h20 && b <= 8'h2B) begin
                s = TXT_W'({b[0] ? 8'h59 : 8'h58, 8'h31 + ((b - 8'h20) >> 1), 8'h54});
            end else if (pfx[7:0] == 8'h5E && b >= 8'h40 && b <= 8'h45) begin
                s = TXT_W'({8'h72, 8'h31 + (b - 8'h40)});
            end else if (pfx[7:0] == 8'h5E && b >= 8'h80 && b <= 8'h82) begin
                s = TXT_W'(8'h75 + (b - 8'h80));
            end else if (pfx[7:0] == 8'hBB && b >= 8'hB0 && b <= 8'hBA) begin
                s = TXT_W'(8'h61 + (b - 8'hB0));
            end else if (pfx[7:0] == 8'hBB && b >= 8'hBC && b <= 8'hCA) begin
                s = TXT_W'(8'h6C + (b - 8'hBC));
            end else begin
                unique case ({pfx[7:0], b})
                    16'h6302: s = "Xscl";
                    16'h6303: s = "Yscl";
                    16'h6304: s = "u(nMin)";
                    16'h6305: s = "v(nMin)";
                    16'h630A: s = "Xmin";
                    16'h630B: s = "Xmax";
                    16'h630C: s = "Ymin";
                    16'h630D: s = "Ymax";
                    16'h630E: s = "Tmin";
                    16'h630F: s = "Tmax";
                    16'h631A: s = "TblStart";
                    16'h631D: s = "nMax";
                    16'h631F: s = "nMin";
                    16'h6321: s = "\xE2\x88\x86Tbl";
                    16'h6336: s = "Xres";
                    16'h7E00: s = "Sequential";
                    16'h7E01: s = "Simul";
                    16'h7E02: s = "PolarGC";
                    16'h7E03: s = "RectGC";
                    16'h7E04: s = "CoordOn";
                    16'h7E05: s = "CoordOff";
                    16'h7E08: s = "AxesOn";
                    16'h7E09: s = "AxesOff";
                    16'h7E0C: s = "LabelOn";
                    16'h7E0D: s = "LabelOff";
                    16'hBB0A: s = "randInt(";
                    16'hBB0B: s = "randBin(";
                    16'hBB0C: s = "sub(";
                    16'hBB0D: s = "stdDev(";
                    16'hBB0E: s = "variance(";
                    16'hBB0F: s = "inString(";
                    16'hBB10: s = "normalcdf(";
                    16'hBB11: s = "invNorm(";
                    16'hBB25: s = "conj(";
                    16'hBB26: s = "real(";
                    16'hBB27: s = "imag(";
                    16'hBB28: s = "angle(";
                    16'hBB29: s = "cumSum(";
                    16'hBB2A: s = "expr(";
                    16'hBB2B: s = "length(";
                    16'hBB2C: s = "\xE2\x88\x86List(";
                    16'hBB2D: s = "ref(";
                    16'hBB2E: s = "rref(";
                    16'hBB2F: s = "\xE2\x96\xB6Rect";
                    16'hBB30: s = "\xE2\x96\xB6Polar";
                    16'hBB31: s = "e";
                    16'hBB39: s = "Matr\xE2\x96\xB6list(";
                    16'hBB3A: s = "List\xE2\x96\xB6matr(";
                    16'hBB50: s = "ExprOn";
                    16'hBB51: s = "ExprOff";
                    16'hBB52: s = "ClrAllLists";
                    16'hBB54: s = "DelVar ";
                    16'hBB55: s = "Equ\xE2\x96\xB6String(";
                    16'hBB56: s = "String\xE2\x96\xB6Equ(";
                    16'hBB57: s = "Clear Entries";
                    16'hBB65: s = "ZoomFit";
                    16'hBB68: s = "Archive ";
                    16'hBB69: s = "UnArchive ";
                    16'hBBA7: s = "\xCF\x80";
                    default:  s = '0;
                endcase
            end
        end
        if (s == '0) begin
            r       = lj(TXT_W'(8'h3F));
            r.known = 1'b0;
        end else begin
            r = lj(s);
        end
        return r;
    endfunction

endpackage

FILE: design/dtok_fifo.sv
// ----------------------------------------------------------------------------
// dtok_fifo - command queue between parser front and text back end
// Register-based FIFO; one push and one pop per cycle.
// ----------------------------------------------------------------------------
module dtok_fifo #(
    parameter int DEPTH = dtok_pkg::FIFO_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dtok_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output dtok_pkg::cmd_t q_data
);
    import dtok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rd_reg];

    always_comb begin
        wr_next  = push ? ((wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
            if (push) begin
                mem_reg[wr_reg] <= push_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop)) else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !q_valid)) else $error("command queue underflow");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH)) else $error("command queue count out of range");
`endif

endmodule

FILE: design/dtok_front.sv
// ----------------------------------------------------------------------------
// dtok_front - container parser
// Tracks position, checks header fields, classifies body tokens, queues commands.
// ----------------------------------------------------------------------------
module dtok_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic           q_full,
    output logic           push,
    output dtok_pkg::cmd_t push_data
);
    import dtok_pkg::*;

    logic [16:0] pos_reg, pos_next;
    logic [15:0] dl_reg, dl_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [15:0] bl_reg, bl_next;
    logic [15:0] bidx_reg, bidx_next;
    logic [8:0]  pend_reg, pend_next;
    logic        named_reg, named_next;
    logic [3:0]  err_reg, err_next;
    logic [15:0] tally_reg, tally_next;

    logic        take, emit;
    logic [16:0] d, hdr17, bl17;
    logic [17:0] body_end;
    logic        in_data;
    logic [8:0]  key;
    tok_rom_t    rom;
    logic [3:0]  code;
    cmd_t        cmd;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_comb begin
        pos_next   = pos_reg;
        dl_next    = dl_reg;
        hdr_next   = hdr_reg;
        bl_next    = bl_reg;
        bidx_next  = bidx_reg;
        pend_next  = pend_reg;
        named_next = named_reg;
        err_next   = err_reg;
        tally_next = tally_reg;
        emit       = 1'b0;
        key        = {1'b0, in_byte};
        code       = ST_OK;
        cmd        = '0;
        cmd.data   = in_byte;

        d        = pos_reg - DATA_POS;
        hdr17    = {1'b0, hdr_reg};
        bl17     = {1'b0, bl_reg};
        in_data  = (pos_reg >= DATA_POS) && (d < {1'b0, dl_reg}) && (err_reg == ST_OK);
        body_end = {1'b0, hdr17} + 18'd4 + {2'b0, in_byte, bl_reg[7:0]};

        if (pend_reg[8]) begin
            key = pend_reg;
        end
        rom = tok_lookup(key, in_byte);

        if (pos_reg < 17'd6) begin
            if (in_byte != sig_byte(pos_reg[2:0]) && err_reg == ST_OK) begin
                err_next = ST_SIG;
            end
        end else if (pos_reg == DATA_LEN_POS) begin
            dl_next = {8'h00, in_byte};
        end else if (pos_reg == DATA_LEN_POS + 17'd1) begin
            dl_next = {in_byte, dl_reg[7:0]};
            if (dl_next < 16'd15 && err_reg == ST_OK) begin
                err_next = ST_HDR_TRUNC;
            end
        end else if (in_data) begin
            if (d == 17'd0) begin
                hdr_next = {8'h00, in_byte};
            end else if (d == 17'd1) begin
                hdr_next = {in_byte, hdr_reg[7:0]};
                if (hdr_next != 16'h000B && hdr_next != 16'h000D) begin
                    err_next = ST_HDR_SIZE;
                end
            end else if (d == 17'd4) begin
                if (in_byte != 8'h05 && in_byte != 8'h06) begin
                    err_next = ST_NOT_PRGM;
                end else if (hdr17 + 17'd4 > {1'b0, dl_reg}) begin
                    err_next = ST_NO_BLEN;
                end
            end else if (d >= 17'd5 && d <= 17'd12) begin
                if (!named_reg) begin
                    if (in_byte == 8'h00) begin
                        named_next = 1'b1;
                    end else if ((in_byte >= 8'h41 && in_byte <= 8'h5A) ||
                                 (in_byte >= 8'h30 && in_byte <= 8'h39)) begin
                        emit   = 1'b1;
                        cmd.op = OP_NAME;
                    end else if (in_byte == 8'h5B) begin
                        emit   = 1'b1;
                        cmd.op = OP_THETA;
                    end
                end
            end else if (d == hdr17 + 17'd2) begin
                bl_next = {8'h00, in_byte};
            end else if (d == hdr17 + 17'd3) begin
                bl_next = {in_byte, bl_reg[7:0]};
                if (body_end > {2'b0, dl_reg}) begin
                    err_next = ST_BODY_PAST;
                end
            end else if (d >= hdr17 + 17'd4 && bidx_reg < bl_reg) begin
                if (!pend_reg[8] && is_prefix(in_byte) &&
                    ({1'b0, bidx_reg} + 17'd1 < bl17)) begin
                    pend_next = {1'b1, in_byte};
                end else begin
                    pend_next = '0;
                    emit      = 1'b1;
                    cmd.op    = OP_TOKEN;
                    cmd.pfx   = key;
                    if (!rom.known && tally_reg != 16'hFFFF) begin
                        tally_next = tally_reg + 16'd1;
                    end
                end
                bidx_next = bidx_reg + 16'd1;
            end
        end

        if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + 17'd1;
        end

        cmd.tally = tally_next;

        if (in_last) begin
            if (pos_next < MIN_FILE) begin
                code = ST_SMALL;
            end else if (err_next == ST_SIG) begin
                code = ST_SIG;
            end else if (dl_next == 16'h0000 || pos_next < {1'b0, dl_next} + MIN_FILE) begin
                code = ST_DLEN;
            end else begin
                code = err_next;
            end
            cmd.has_status = 1'b1;
            cmd.code       = code;
            cmd.scount     = (code == ST_OK) ? tally_next : 16'h0000;
            pos_next   = '0;
            dl_next    = '0;
            hdr_next   = '0;
            bl_next    = '0;
            bidx_next  = '0;
            pend_next  = '0;
            named_next = 1'b0;
            err_next   = ST_OK;
            tally_next = '0;
        end
    end

    assign push      = take && (emit || in_last);
    assign push_data = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            dl_reg    <= '0;
            hdr_reg   <= '0;
            bl_reg    <= '0;
            bidx_reg  <= '0;
            pend_reg  <= '0;
            named_reg <= 1'b0;
            err_reg   <= ST_OK;
            tally_reg <= '0;
        end else if (take) begin
            pos_reg   <= pos_next;
            dl_reg    <= dl_next;
            hdr_reg   <= hdr_next;
            bl_reg    <= bl_next;
            bidx_reg  <= bidx_next;
            pend_reg  <= pend_next;
            named_reg <= named_next;
            err_reg   <= err_next;
            tally_reg <= tally_next;
        end
    end

endmodule

FILE: design/dtok_back.sv
// ----------------------------------------------------------------------------
// dtok_back - text serializer
// Emits a command's text bytes and any status, one per cycle unless held off.
// ----------------------------------------------------------------------------
module dtok_back #(
    parameter int MAX_TOKEN_BYTES = dtok_pkg::MAX_TOKEN_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  dtok_pkg::cmd_t q_data,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_kind,
    output logic [7:0]     out_char,
    output logic [3:0]     out_code,
    output logic [15:0]    out_count,
    output logic           out_last
);
    import dtok_pkg::*;

    logic             busy_reg;
    logic [1:0]       kind_reg;
    logic [TXT_W-1:0] txt_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [15:0]      tally_reg;
    logic             hst_reg;
    logic [3:0]       code_reg;
    logic [15:0]      scnt_reg;

    logic             ov_reg;
    logic [1:0]       okind_reg;
    logic [7:0]       ochar_reg;
    logic [3:0]       ocode_reg;
    logic [15:0]      ocnt_reg;
    logic             olast_reg;

    logic             out_free, adv, fin, load;
    tok_rom_t         rom, ld;

    assign out_free = !ov_reg || out_ready;
    assign adv      = busy_reg && out_free;
    assign fin      = (rem_reg == '0) || (rem_reg == LEN_W'(1) && !hst_reg);
    assign load     = q_valid && (!busy_reg || (adv && fin));
    assign pop      = load;

    always_comb begin
        rom = tok_lookup(q_data.pfx, q_data.data);
        ld  = '0;
        unique case (q_data.op)
            OP_NAME: begin
                ld.txt = {q_data.data, {(TXT_W - 8){1'b0}}};
                ld.len = LEN_W'(1);
            end
            OP_THETA: ld = lj(TXT_W'("theta"));
            OP_TOKEN: begin
                ld = rom;
                if (int'(rom.len) > MAX_TOKEN_BYTES) begin
                    ld.len = LEN_W'(MAX_TOKEN_BYTES);
                end
            end
            default: ld = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            if (out_free) begin
                ov_reg <= busy_reg;
            end
            if (adv) begin
                if (rem_reg != '0) begin
                    okind_reg <= kind_reg;
                    ochar_reg <= txt_reg[TXT_W-1 -: 8];
                    ocode_reg <= ST_OK;
                    ocnt_reg  <= tally_reg;
                    if (!fin) begin
                        txt_reg <= txt_reg << 8;
                        rem_reg <= rem_reg - 1'b1;
                    end
                end else begin
                    okind_reg <= KIND_STATUS;
                    ochar_reg <= 8'h00;
                    ocode_reg <= code_reg;
                    ocnt_reg  <= scnt_reg;
                end
                olast_reg <= fin;
            end
            if (load) begin
                busy_reg  <= 1'b1;
                kind_reg  <= (q_data.op == OP_TOKEN) ? KIND_TEXT : KIND_NAME;
                txt_reg   <= ld.txt;
                rem_reg   <= ld.len;
                tally_reg <= q_data.tally;
                hst_reg   <= q_data.has_status;
                code_reg  <= q_data.code;
                scnt_reg  <= q_data.scount;
            end else if (adv && fin) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_kind  = okind_reg;
    assign out_char  = ochar_reg;
    assign out_code  = ocode_reg;
    assign out_count = ocnt_reg;
    assign out_last  = olast_reg;

endmodule

FILE: design/tokenized_program_detokenizer.sv
// ----------------------------------------------------------------------------
// tokenized_program_detokenizer - streaming program file detokenizer
// Checks a program container byte by byte, emits name and decoded source text.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                 | tuser     | tlast
//  s_      | in  | [7:0] file byte                       | -         | last byte of file
//  m_      | out | [7:0] char, [11:8] status, [27:12] unk | [1:0] kind | last result of byte
//
//  Rates: the parser takes one byte per cycle while the command queue is not
//  full; the serializer emits one result per cycle unless m_tready holds it
//  off. A byte causes up to 13 text bytes plus one status result.
//  Reset: synchronous, active low; clears all parse state and the queue.
//  Stalls: m_tready low fills the command queue (FIFO_DEPTH entries); the
//  input then stalls through s_tready. Results already queued are kept.
// ----------------------------------------------------------------------------
module tokenized_program_detokenizer #(
    parameter int MAX_TOKEN_BYTES = dtok_pkg::MAX_TOKEN_BYTES_DEF,
    parameter int FIFO_DEPTH      = dtok_pkg::FIFO_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_char, [11:8] status_code, [27:12] unknown_count
    output logic [1:0]  m_tuser,   // [1:0] out_kind
    output logic        m_tlast    // last_of_run
);
    import dtok_pkg::*;

    logic        push, pop, q_full, q_valid;
    cmd_t        push_data, q_data;
    logic [3:0]  out_code;
    logic [15:0] out_count;
    logic [7:0]  out_char;

    // front: header checks and token classification, one byte per transfer
    dtok_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // decouples parsing from text expansion
    dtok_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    // back: expands each command into result transfers
    dtok_back #(
        .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_char  (out_char),
        .out_code  (out_code),
        .out_count (out_count),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, out_count, out_code, out_char};

endmodule

FILE: test/tokenized_program_detokenizer_tb.sv
// ----------------------------------------------------------------------------
// tokenized_program_detokenizer_tb - self-checking bench for the detokenizer
// Streams whole program files byte by byte, predicts name/text/status results
// with an independent model and compares every output transfer in order.
// ----------------------------------------------------------------------------
module tokenized_program_detokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dtok_pkg::*;

    localparam int TOK_CAP = 16;

    // one expected output transfer
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [3:0]  code;
        logic [15:0] cnt;
        logic        last;
    } res_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predictor state plus the queue of pending expectations
    // ------------------------------------------------------------------------
    class detok_scoreboard;
        res_t        pending[$];
        int          errors;
        logic [16:0] pos;
        logic [15:0] dlen, hsize, blen, bidx, tally;
        logic [8:0]  pfx;
        logic        name_end;
        logic [3:0]  err;
        res_t        step_q[$];

        function void clear();
            pos = 0; dlen = 0; hsize = 0; blen = 0; bidx = 0;
            pfx = 0; name_end = 0; err = ST_OK; tally = 0;
        endfunction

        function void push(logic [1:0] k, logic [7:0] c, logic [3:0] s, logic [15:0] n);
            res_t r;
            if (step_q.size() >= TOK_CAP) return;
            r.kind = k; r.ch = c; r.code = s; r.cnt = n; r.last = 0;
            step_q.push_back(r);
        endfunction

        function void push_text(logic [1:0] k, string s);
            for (int i = 0; i < s.len() && i < TOK_CAP; i++)
                push(k, s[i], ST_OK, tally);
        endfunction

        function string one_text(logic [7:0] b);
            string t[int];
            t = '{8'h01:"\xE2\x96\xB6DMS",8'h02:"\xE2\x96\xB6Dec",8'h03:"\xE2\x96\xB6Frac",
                8'h04:"\xE2\x86\x92",8'h05:"Boxplot",8'h06:"[",8'h07:"]",8'h08:"{",
                8'h09:"}",8'h0A:"\xCA\xB3",8'h0B:"\xC2\xB0",8'h0C:"^-1",8'h0D:"^2",
                8'h0E:"^T",8'h0F:"^3",8'h10:"(",8'h11:")",8'h12:"round(",
                8'h13:"pxl-Test(",8'h14:"augment(",8'h15:"rowSwap(",8'h16:"row+(",
                8'h17:"*row(",8'h18:"*row+(",8'h19:"max(",8'h1A:"min(",
                8'h1B:"R\xE2\x96\xB6Pr(",8'h1C:"R\xE2\x96\xB6P\xCE\xB8(",
                8'h1D:"P\xE2\x96\xB6Rx(",8'h1E:"P\xE2\x96\xB6Ry(",8'h1F:"median(",
                8'h20:"randM(",8'h21:"mean(",8'h22:"solve(",8'h23:"seq(",
                8'h24:"fnInt(",8'h25:"nDeriv(",8'h27:"fMin(",8'h28:"fMax(",8'h29:" ",
                8'h2A:"\"",8'h2B:",",8'h2C:"i",8'h2D:"!",8'h2E:"CubicReg ",
                8'h2F:"QuartReg ",8'h30:"0",8'h31:"1",8'h32:"2",8'h33:"3",8'h34:"4",
                8'h35:"5",8'h36:"6",8'h37:"7",8'h38:"8",8'h39:"9",8'h3A:".",8'h3B:"E",
                8'h3C:" xor ",8'h3E:":",8'h3F:"\n",8'h40:" and ",8'h41:"A",8'h42:"B",
                8'h43:"C",8'h44:"D",8'h45:"E",8'h46:"F",8'h47:"G",8'h48:"H",8'h49:"I",
                8'h4A:"J",8'h4B:"K",8'h4C:"L",8'h4D:"M",8'h4E:"N",8'h4F:"O",8'h50:"P",
                8'h51:"Q",8'h52:"R",8'h53:"S",8'h54:"T",8'h55:"U",8'h56:"V",8'h57:"W",
                8'h58:"X",8'h59:"Y",8'h5A:"Z",8'h5B:"\xCE\xB8",8'h5F:"prgm",
                8'h64:"Radian",8'h65:"Degree",8'h66:"Normal",8'h67:"Sci",8'h68:"Eng",
                8'h69:"Float",8'h6A:"=",8'h6B:"<",8'h6C:">",8'h6D:"\xE2\x89\xA4",
                8'h6E:"\xE2\x89\xA5",8'h6F:"\xE2\x89\xA0",8'h70:"+",8'h71:"-",
                8'h72:"Ans",8'h73:"Fix ",8'h74:"Horiz",8'h75:"Full",8'h76:"Func",
                8'h77:"Param",8'h78:"Polar",8'h79:"Seq",8'h82:"*",8'h83:"/",
                8'h84:"Trace",8'h85:"ClrDraw",8'h86:"ZStandard",8'h87:"ZTrig",
                8'h88:"ZBox",8'h89:"Zoom In",8'h8A:"Zoom Out",8'h8B:"ZSquare",
                8'h8C:"ZInteger",8'h8D:"ZPrevious",8'h8E:"ZDecimal",8'h8F:"ZoomStat",
                8'h90:"ZoomRcl",8'h91:"PrintScreen",8'h92:"ZoomSto",8'h93:"Text(",
                8'h94:" nPr ",8'h95:" nCr ",8'h96:"FnOn ",8'h97:"FnOff ",
                8'h98:"StorePic ",8'h99:"RecallPic ",8'h9A:"StoreGDB ",
                8'h9B:"RecallGDB ",8'h9C:"Line(",8'h9D:"Vertical ",8'h9E:"Pt-On(",
                8'h9F:"Pt-Off(",8'hA0:"Pt-Change(",8'hA1:"Pxl-On(",8'hA2:"Pxl-Off(",
                8'hA3:"Pxl-Change(",8'hA4:"Shade(",8'hA5:"Circle(",
                8'hA6:"Horizontal ",8'hA7:"Tangent(",8'hA8:"DrawInv ",8'hA9:"DrawF ",
                8'hAB:"rand",8'hAC:"\xCF\x80",8'hAD:"getKey",8'hAE:"'",8'hAF:"?",
                8'hB0:"-",8'hB1:"int(",8'hB2:"abs(",8'hB3:"det(",8'hB4:"identity(",
                8'hB5:"dim(",8'hB6:"sum(",8'hB7:"prod(",8'hB8:"not(",8'hB9:"iPart(",
                8'hBA:"fPart(",8'hBC:"\xE2\x88\x9A(",8'hBD:"\xC2\xB3\xE2\x88\x9A(",
                8'hBE:"ln(",8'hBF:"e^(",8'hC0:"log(",8'hC1:"10^(",8'hC2:"sin(",
                8'hC3:"sin^-1(",8'hC4:"cos(",8'hC5:"cos^-1(",8'hC6:"tan(",
                8'hC7:"tan^-1(",8'hC8:"sinh(",8'hC9:"sinh^-1(",8'hCA:"cosh(",
                8'hCB:"cosh^-1(",8'hCC:"tanh(",8'hCD:"tanh^-1(",8'hCE:"If ",
                8'hCF:"Then",8'hD0:"Else",8'hD1:"While ",8'hD2:"Repeat ",8'hD3:"For(",
                8'hD4:"End",8'hD5:"Return",8'hD6:"Lbl ",8'hD7:"Goto ",8'hD8:"Pause ",
                8'hD9:"Stop",8'hDA:"IS>(",8'hDB:"DS<(",8'hDC:"Input ",8'hDD:"Prompt ",
                8'hDE:"Disp ",8'hDF:"DispGraph",8'hE0:"Output(",8'hE1:"ClrHome",
                8'hE2:"Fill(",8'hE3:"SortA(",8'hE4:"SortD(",8'hE5:"DispTable",
                8'hE6:"Menu(",8'hE7:"Send(",8'hE8:"Get(",8'hE9:"PlotsOn ",
                8'hEA:"PlotsOff ",8'hEB:"L",8'hEC:"Plot1(",8'hED:"Plot2(",
                8'hEE:"Plot3(",8'hF0:"^",8'hF1:"\xCB\xA3\xE2\x88\x9A",
                8'hF2:"1-Var Stats ",8'hF3:"2-Var Stats ",8'hF4:"LinReg(a+bx) ",
                8'hF5:"ExpReg ",8'hF6:"LnReg ",8'hF7:"PwrReg ",8'hF8:"Med-Med ",
                8'hF9:"QuadReg ",8'hFA:"ClrList ",8'hFB:"ClrTable",8'hFC:"Histogram",
                8'hFD:"xyLine",8'hFE:"Scatter",8'hFF:"LinReg(ax+b) "};
            return t.exists(b) ? t[b] : "";
        endfunction

        function string pair_str(logic [7:0] p, logic [7:0] s);
            string t[int];
            string g;
            g = "";
            if (p == 8'h5C && s < 10) begin g = "[ ]"; g[1] = 8'h41 + s; return g; end
            if ((p == 8'h60 || p == 8'hAA) && s < 10) begin
                g = (p == 8'h60) ? "Pic0" : "Str0"; g[3] = 8'h30 + (s + 1) % 10; return g;
            end
            if (p == 8'h5D && s < 6) begin g = "L1"; g[1] = 8'h31 + s; return g; end
            if (p == 8'h5E) begin
                if (s >= 8'h10 && s <= 8'h19) begin
                    g = "Y0"; g[1] = 8'h30 + (s - 8'h0F) % 10; return g;
                end
                if (s >= 8'h20 && s <= 8'h2B) begin
                    g = s[0] ? "Y1T" : "X1T"; g[1] = 8'h31 + (s - 8'h20) / 2; return g;
                end
                if (s >= 8'h40 && s <= 8'h45) begin g = "r1"; g[1] = 8'h31 + s - 8'h40; return g; end
                if (s >= 8'h80 && s <= 8'h82) begin g = "u"; g[0] = 8'h75 + s - 8'h80; return g; end
            end
            if (p == 8'hBB) begin
                if (s >= 8'hB0 && s <= 8'hBA) begin g = "a"; g[0] = 8'h61 + s - 8'hB0; return g; end
                if (s >= 8'hBC && s <= 8'hCA) begin g = "l"; g[0] = 8'h6C + s - 8'hBC; return g; end
            end
            t = '{16'h6302:"Xscl",16'h6303:"Yscl",16'h6304:"u(nMin)",16'h6305:"v(nMin)",
                16'h630A:"Xmin",16'h630B:"Xmax",16'h630C:"Ymin",16'h630D:"Ymax",
                16'h630E:"Tmin",16'h630F:"Tmax",16'h631A:"TblStart",16'h631D:"nMax",
                16'h631F:"nMin",16'h6321:"\xE2\x88\x86Tbl",16'h6336:"Xres",
                16'h7E00:"Sequential",16'h7E01:"Simul",16'h7E02:"PolarGC",
                16'h7E03:"RectGC",16'h7E04:"CoordOn",16'h7E05:"CoordOff",
                16'h7E08:"AxesOn",16'h7E09:"AxesOff",16'h7E0C:"LabelOn",
                16'h7E0D:"LabelOff",16'hBB0A:"randInt(",16'hBB0B:"randBin(",
                16'hBB0C:"sub(",16'hBB0D:"stdDev(",16'hBB0E:"variance(",
                16'hBB0F:"inString(",16'hBB10:"normalcdf(",16'hBB11:"invNorm(",
                16'hBB25:"conj(",16'hBB26:"real(",16'hBB27:"imag(",16'hBB28:"angle(",
                16'hBB29:"cumSum(",16'hBB2A:"expr(",16'hBB2B:"length(",
                16'hBB2C:"\xE2\x88\x86List(",16'hBB2D:"ref(",16'hBB2E:"rref(",
                16'hBB2F:"\xE2\x96\xB6Rect",16'hBB30:"\xE2\x96\xB6Polar",16'hBB31:"e",
                16'hBB39:"Matr\xE2\x96\xB6list(",16'hBB3A:"List\xE2\x96\xB6matr(",
                16'hBB50:"ExprOn",16'hBB51:"ExprOff",16'hBB52:"ClrAllLists",
                16'hBB54:"DelVar ",16'hBB55:"Equ\xE2\x96\xB6String(",
                16'hBB56:"String\xE2\x96\xB6Equ(",16'hBB57:"Clear Entries",
                16'hBB65:"ZoomFit",16'hBB68:"Archive ",16'hBB69:"UnArchive ",
                16'hBBA7:"\xCF\x80"};
            return t.exists({p, s}) ? t[{p, s}] : "";
        endfunction

        function void emit_token(string s);
            if (s.len() == 0) begin
                if (tally != 16'hFFFF) tally++;
                push(KIND_TEXT, "?", ST_OK, tally);
            end else
                push_text(KIND_TEXT, s);
        endfunction

        function void note_error(logic [3:0] c);
            if (err == ST_OK) err = c;
        endfunction

        function bit is_pfx(logic [7:0] b);
            return b == 8'h5C || b == 8'h5D || b == 8'h5E || b == 8'h60 || b == 8'h62 ||
                   b == 8'h63 || b == 8'h7E || b == 8'hAA || b == 8'hBB || b == 8'hEF;
        endfunction

        // accepted input transfer: predict the results it causes
        function void note_input(logic [7:0] b, logic lst);
            logic [16:0] d;
            logic [3:0]  code;
            logic [16:0] sz;
            string sig;
            sig = "**TI83";
            step_q.delete();
            d = pos - DATA_POS;
            if (pos < 6) begin
                if (b != sig[pos]) note_error(ST_SIG);
            end else if (pos == DATA_LEN_POS) begin
                dlen = b;
            end else if (pos == DATA_LEN_POS + 1) begin
                dlen[15:8] = b;
                if (dlen < 15) note_error(ST_HDR_TRUNC);
            end else if (pos >= DATA_POS && d < dlen && err == ST_OK) begin
                if (d == 0) hsize = b;
                else if (d == 1) begin
                    hsize[15:8] = b;
                    if (hsize != 16'h0B && hsize != 16'h0D) note_error(ST_HDR_SIZE);
                end else if (d == 4) begin
                    if (b != 8'h05 && b != 8'h06) note_error(ST_NOT_PRGM);
                    else if (17'(hsize) + 4 > dlen) note_error(ST_NO_BLEN);
                end else if (d >= 5 && d <= 12) begin
                    if (!name_end) begin
                        if (b == 0) name_end = 1;
                        else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h30 && b <= 8'h39))
                            push(KIND_NAME, b, ST_OK, tally);
                        else if (b == 8'h5B) push_text(KIND_NAME, "theta");
                    end
                end else if (d == 17'(hsize) + 2) begin
                    blen = b;
                end else if (d == 17'(hsize) + 3) begin
                    blen[15:8] = b;
                    if (18'(hsize) + 4 + 18'(blen) > 18'(dlen)) note_error(ST_BODY_PAST);
                end else if (d >= 17'(hsize) + 4 && bidx < blen) begin
                    if (pfx[8]) begin
                        emit_token(pair_str(pfx[7:0], b));
                        pfx = 0;
                    end else if (is_pfx(b) && 17'(bidx) + 1 < 17'(blen))
                        pfx = {1'b1, b};
                    else
                        emit_token(one_text(b));
                    bidx++;
                end
            end
            if (pos != POS_MAX) pos++;
            if (lst) begin
                sz = pos;
                if (sz < MIN_FILE) code = ST_SMALL;
                else if (err == ST_SIG) code = ST_SIG;
                else if (dlen == 0 || 18'(sz) < 18'(dlen) + 18'(MIN_FILE)) code = ST_DLEN;
                else code = err;
                push(KIND_STATUS, 8'h00, code, code == ST_OK ? tally : 16'h0);
                clear();
            end
            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
            foreach (step_q[i]) pending.push_back(step_q[i]);
        endfunction

        function void check_output(logic [1:0] k, logic [31:0] dat, logic lst);
            res_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d data=%h last=%b",
                         $realtime, k, dat, lst);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind || dat[7:0] !== e.ch || dat[11:8] !== e.code ||
                dat[27:12] !== e.cnt || lst !== e.last || dat[31:28] !== 4'h0) begin
                $display("%0t: mismatch exp kind=%0d char=%h code=%0d cnt=%0d last=%b",
                         $realtime, e.kind, e.ch, e.code, e.cnt, e.last);
                $display("%0t:          got kind=%0d char=%h code=%0d cnt=%0d last=%b",
                         $realtime, k, dat[7:0], dat[11:8], dat[27:12], lst);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    detok_scoreboard sb;
    bit          stall_rx = 0;    // long receiver hold-off while set

    tokenized_program_detokenizer i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // file image being built for the sender
    logic [7:0] file_q[$];

    // offer one byte; waits for the transfer, random gap first
    task automatic send_byte(logic [7:0] b, logic lst, bit nogap = 0);
        int gap;
        gap = nogap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1; s_tdata <= b; s_tlast <= lst;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, lst);
        @(negedge aclk);
    endtask

    task automatic send_file(bit nogap = 0);
        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1, nogap);
        s_tvalid <= 0;
        @(negedge aclk);
    endtask

    // well-formed program file; body tokens from the caller's queue
    task automatic build_file(logic [7:0] body[$], logic [15:0] hsz, logic [7:0] kind,
                              logic [7:0] nm[8], int tail);
        int dl;
        file_q.delete();
        file_q = '{8'h2A, 8'h2A, 8'h54, 8'h49, 8'h38, 8'h33};
        repeat (DATA_LEN_POS - 6) file_q.push_back(8'($urandom_range(0, 255)));
        dl = hsz + 4 + body.size();
        file_q.push_back(dl[7:0]); file_q.push_back(dl[15:8]);
        file_q.push_back(hsz[7:0]); file_q.push_back(hsz[15:8]);
        file_q.push_back(8'($urandom_range(0, 255)));
        file_q.push_back(8'($urandom_range(0, 255)));
        file_q.push_back(kind);
        for (int i = 0; i < 8; i++) file_q.push_back(nm[i]);
        repeat (hsz - 11) file_q.push_back(8'($urandom_range(0, 255)));
        file_q.push_back(8'(body.size() % 256)); file_q.push_back(8'(body.size() / 256));
        foreach (body[i]) file_q.push_back(body[i]);
        // checksum
        repeat (2) file_q.push_back(8'($urandom_range(0, 255)));
        repeat (tail) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drain();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // receiver: random ready, with an optional long hold-off
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_rx) begin
                m_tready <= 0;
            end else begin
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
                if (gap != 0) begin
                    m_tready <= 0;
                    repeat (gap) @(negedge aclk);
                end
                m_tready <= 1;
            end
        end
    end

    // output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_output(m_tuser, m_tdata, m_tlast);
    end

    // receiver hold-off counted in cycles
    task automatic hold_rx(int cycles);
        stall_rx = 1;
        repeat (cycles) @(negedge aclk);
        stall_rx = 0;
    endtask

    initial begin
        #3_000_000;
        $display("tokenized_program_detokenizer verification failed");
        $finish;
    end

    initial begin
        logic [7:0] body[$];
        logic [7:0] nm[8];
        sb = new();
        sb.clear();
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: tiny files
        file_q = '{8'h00};
        send_file();
        file_q = '{8'hFF, 8'h00, 8'h80};
        send_file();
        // longest tokens, prefix as final body byte, unknown tokens
        nm = '{8'h5B, 8'h5A, 8'h30, 8'h61, 8'hFF, 8'h5B, 8'h5B, 8'h5B};
        body = '{8'hF4, 8'hFF, 8'hBB, 8'h57, 8'hBB, 8'h39, 8'h26, 8'hEF, 8'h00,
                 8'h5E, 8'h19, 8'h60, 8'h09, 8'hBB};
        build_file(body, 16'h0D, 8'h06, nm, 0);
        send_file();
        wait_drain();

        // pressure: block the receiver while a long-token file streams in
        body.delete();
        repeat (4) body.push_back(8'hF4);
        build_file(body, 16'h0B, 8'h05, nm, 0);
        fork
            hold_rx(400);
            send_file(1);
        join
        wait_drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tokenized_program_detokenizer verification clean");
        else
            $display("tokenized_program_detokenizer verification failed");
        $finish;
    end
endmodule
